[rtl/core/ask_pkg.sv]
// Package for the antiplane s13 stress kernel: payload structs, widths,
// fixed-point constants and status codes. No dependencies.
`timescale 1ns / 1ps

package ask_pkg;

  localparam int FRAC_BITS = 16;

  localparam int IN_W   = 32;                 // input coordinate width
  localparam int DM_W   = IN_W + 1;           // |x2 - y2|
  localparam int QM_W   = IN_W + 2;           // |image depth offset|
  localparam int DSQ_W  = 2 * DM_W;
  localparam int QSQ_W  = 2 * QM_W;
  localparam int DEN_W  = QSQ_W + 1;          // d^2 + q^2
  localparam int Q_W    = 2 * FRAC_BITS + 1;  // quotient bits, one per divider stage
  localparam int SUM_W  = Q_W + 3;
  localparam int SM_W   = Q_W + 2;
  localparam int RIG_W  = 32;
  localparam int K_W    = 32;
  localparam int P1_W   = SM_W + RIG_W;
  localparam int PLO_W  = 32;
  localparam int PHI_W  = P1_W - PLO_W;
  localparam int P_W    = P1_W + K_W + 1;
  localparam int SHR    = FRAC_BITS + 32;
  localparam int R_W    = P_W - SHR;
  localparam int OUT_W  = 48;
  localparam int RX_W   = (R_W > OUT_W + 1) ? R_W : OUT_W + 1;

  localparam logic [K_W-1:0]   INV_TWO_PI_Q32 = 32'd683565276;
  localparam logic [RIG_W-1:0] RIGIDITY_RESET = RIG_W'(1) << FRAC_BITS;
  localparam logic [OUT_W-1:0] SINGULAR_VALUE =
    ~(OUT_W'(999) << FRAC_BITS) + OUT_W'(1);
  localparam logic [RX_W-1:0]  MAG_MAX_POS = (RX_W'(1) << (OUT_W - 1)) - RX_W'(1);
  localparam logic [RX_W-1:0]  MAG_MAX_NEG = RX_W'(1) << (OUT_W - 1);

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SAT      = 2'd1;
  localparam logic [1:0] STATUS_SINGULAR = 2'd2;

  typedef struct packed {
    logic signed [IN_W-1:0] receiver_horizontal;
    logic signed [IN_W-1:0] receiver_depth;
    logic signed [IN_W-1:0] source_horizontal;
    logic signed [IN_W-1:0] source_top_depth;
    logic signed [IN_W-1:0] source_center_depth;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] stress_value;
    logic [1:0]              status;
  } out_t;

endpackage

[rtl/core/ask_div_lane.sv]
// Pipelined restoring divider lane: floor(dm * 2^(2F) / den), one quotient
// bit per stage. Depends on ask_pkg.
`timescale 1ns / 1ps

module ask_div_lane (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [ask_pkg::DM_W-1:0]     dm_i,
  input  logic [ask_pkg::DEN_W-1:0]    den_i,
  output logic [ask_pkg::Q_W-1:0]      quot_o
);

  localparam int QW = ask_pkg::Q_W;
  localparam int DW = ask_pkg::DEN_W;

  logic [DW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  logic [DW-1:0] rem_in [QW];
  logic [DW-1:0] den_in [QW];
  logic [QW-1:0] quo_in [QW];
  logic          bit_in [QW];

  genvar j;
  generate
    for (j = 0; j < QW; j++) begin : g_stage
      logic [DW:0]   sh;
      logic [DW:0]   diff;
      logic          ge;

      if (j == 0) begin : g_first
        // Numerator bits above the quotient range collapse to dm >> 1.
        assign rem_in[j] = DW'(dm_i[ask_pkg::DM_W-1:1]);
        assign den_in[j] = den_i;
        assign quo_in[j] = '0;
        assign bit_in[j] = dm_i[0];
      end else begin : g_next
        assign rem_in[j] = rem_q[j-1];
        assign den_in[j] = den_q[j-1];
        assign quo_in[j] = quo_q[j-1];
        assign bit_in[j] = 1'b0;
      end

      assign sh   = {rem_in[j], bit_in[j]};
      assign diff = sh - {1'b0, den_in[j]};
      assign ge   = (sh >= {1'b0, den_in[j]});

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= ge ? diff[DW-1:0] : sh[DW-1:0];
          den_q[j] <= den_in[j];
          quo_q[j] <= {quo_in[j][QW-2:0], ge};
        end
      end
    end
  endgenerate

  assign quot_o = quo_q[QW-1];

endmodule

[rtl/core/antiplane_stress_kernel_s13.sv]
// Top level of the antiplane s13 stress kernel: front-end, four divider
// lanes, sum, scaling and saturation. Depends on ask_pkg and ask_div_lane.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i / in_ready_o / in_data_i): one transaction is one
//   receiver / strip-source pair in signed Q16.16.
//   Output channel (out_valid_o / out_ready_i / out_data_o): one transaction per
//   input, in order, holding the kernel value and its status
//   (ok, saturated, singular with value -999).
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): writes rigidity;
//   always ready. Write it only while no transaction is in flight.
// Depth: 43 register stages at FRAC_BITS = 16, the first one loaded at the
//   accepting edge. The four restoring divider lanes set the depth: one
//   quotient bit per stage.
// Throughput: one pair per cycle while the receiver keeps taking results.
// Stall: when the output register holds an untaken result the whole pipeline
//   holds and in_ready_o drops; nothing is lost or repeated.
// Reset: clears all valid bits; rigidity returns to 1.0.

module antiplane_stress_kernel_s13 (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ask_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ask_pkg::out_t  out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [31:0]    cfg_data_i
);

  localparam int QW  = ask_pkg::Q_W;
  localparam int DMW = ask_pkg::DM_W;
  localparam int QMW = ask_pkg::QM_W;

  // Advance every stage together unless the output register is stuck.
  logic en;
  logic out_valid_q;
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  // Rigidity register.
  logic [ask_pkg::RIG_W-1:0] rigidity_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rigidity_q <= ask_pkg::RIGIDITY_RESET;
    end else if (cfg_valid_i) begin
      rigidity_q <= cfg_data_i;
    end
  end

  // ---------------- Stage 1: differences ----------------
  logic signed [DMW-1:0] d_1_d, a_1_d, b_1_d, t_1_d;
  logic [DMW-1:0]        wm_1_d;
  logic signed [DMW-1:0] d_1_q, a_1_q, b_1_q;
  logic [DMW-1:0]        wm_1_q;
  logic                  vld_1_q;

  always_comb begin
    d_1_d  = DMW'(in_data_i.receiver_horizontal) - DMW'(in_data_i.source_horizontal);
    a_1_d  = DMW'(in_data_i.receiver_depth) - DMW'(in_data_i.source_top_depth);
    b_1_d  = DMW'(in_data_i.receiver_depth) + DMW'(in_data_i.source_top_depth);
    t_1_d  = DMW'(in_data_i.source_top_depth) - DMW'(in_data_i.source_center_depth);
    wm_1_d = t_1_d[DMW-1] ? (~t_1_d + DMW'(1)) : t_1_d;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_1_q  <= d_1_d;
      a_1_q  <= a_1_d;
      b_1_q  <= b_1_d;
      wm_1_q <= wm_1_d;
    end
  end

  // ---------------- Stage 2: magnitudes of d and the four image offsets ----
  logic signed [QMW:0] qs_2_d [4];
  logic [QMW-1:0]      qm_2_d [4];
  logic [QMW-1:0]      qm_2_q [4];
  logic [DMW-1:0]      dm_2_d, dm_2_q;
  logic                dneg_2_q, vld_2_q;

  always_comb begin
    qs_2_d[0] = (QMW+1)'(a_1_q);
    qs_2_d[1] = (QMW+1)'(b_1_q);
    qs_2_d[2] = (QMW+1)'(a_1_q) - (QMW+1)'({wm_1_q, 1'b0});
    qs_2_d[3] = (QMW+1)'(b_1_q) + (QMW+1)'({wm_1_q, 1'b0});
    for (int k = 0; k < 4; k++) begin
      qm_2_d[k] = qs_2_d[k][QMW] ? QMW'(~qs_2_d[k] + (QMW+1)'(1)) : QMW'(qs_2_d[k]);
    end
    dm_2_d = d_1_q[DMW-1] ? (~d_1_q + DMW'(1)) : d_1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qm_2_q   <= qm_2_d;
      dm_2_q   <= dm_2_d;
      dneg_2_q <= d_1_q[DMW-1];
    end
  end

  // ---------------- Stage 3: squares, singular check ----------------
  logic [ask_pkg::DSQ_W-1:0] dsq_3_q;
  logic [ask_pkg::QSQ_W-1:0] qsq_3_q [4];
  logic [DMW-1:0]            dm_3_q;
  logic                      dneg_3_q, sing_3_q, vld_3_q;
  logic                      qzero_2;

  always_comb begin
    qzero_2 = 1'b0;
    for (int k = 0; k < 4; k++) begin
      qzero_2 = qzero_2 | (qm_2_q[k] == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dsq_3_q  <= ask_pkg::DSQ_W'(dm_2_q) * ask_pkg::DSQ_W'(dm_2_q);
      for (int k = 0; k < 4; k++) begin
        qsq_3_q[k] <= ask_pkg::QSQ_W'(qm_2_q[k]) * ask_pkg::QSQ_W'(qm_2_q[k]);
      end
      dm_3_q   <= dm_2_q;
      dneg_3_q <= dneg_2_q;
      sing_3_q <= (dm_2_q == '0) && qzero_2;
    end
  end

  // ---------------- Stage 4: denominators ----------------
  logic [ask_pkg::DEN_W-1:0] den_4_q [4];
  logic [DMW-1:0]            dm_4_q;
  logic                      dneg_4_q, sing_4_q, vld_4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        den_4_q[k] <= ask_pkg::DEN_W'(dsq_3_q) + ask_pkg::DEN_W'(qsq_3_q[k]);
      end
      dm_4_q   <= dm_3_q;
      dneg_4_q <= dneg_3_q;
      sing_4_q <= sing_3_q;
    end
  end

  // ---------------- Divider lanes ----------------
  logic [QW-1:0] quot [4];

  genvar k;
  generate
    for (k = 0; k < 4; k++) begin : g_lane
      ask_div_lane u_div (
        .clk_i  (clk_i),
        .en_i   (en),
        .dm_i   (dm_4_q),
        .den_i  (den_4_q[k]),
        .quot_o (quot[k])
      );
    end
  endgenerate

  // Side info rides alongside the divider stages.
  logic tvld_q  [QW];
  logic tdneg_q [QW];
  logic tsing_q [QW];

  generate
    for (k = 0; k < QW; k++) begin : g_tag
      if (k == 0) begin : g_first
        always_ff @(posedge clk_i) begin
          if (en) begin
            tdneg_q[k] <= dneg_4_q;
            tsing_q[k] <= sing_4_q;
          end
        end
        always_ff @(posedge clk_i or negedge rst_ni) begin
          if (!rst_ni) tvld_q[k] <= 1'b0;
          else if (en) tvld_q[k] <= vld_4_q;
        end
      end else begin : g_next
        always_ff @(posedge clk_i) begin
          if (en) begin
            tdneg_q[k] <= tdneg_q[k-1];
            tsing_q[k] <= tsing_q[k-1];
          end
        end
        always_ff @(posedge clk_i or negedge rst_ni) begin
          if (!rst_ni) tvld_q[k] <= 1'b0;
          else if (en) tvld_q[k] <= tvld_q[k-1];
        end
      end
    end
  endgenerate

  // ---------------- Stage 5: signed sum of the four image terms ----------
  // Terms one and four add, two and three subtract; a negative d flips all.
  logic signed [ask_pkg::SUM_W-1:0] term_5 [4];
  logic signed [ask_pkg::SUM_W-1:0] sum_5_d, sum_5_q;
  logic                             sing_5_q, vld_5_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic flip;
      flip = ((i == 1) || (i == 2)) ^ tdneg_q[QW-1];
      term_5[i] = flip ? -ask_pkg::SUM_W'(quot[i]) : ask_pkg::SUM_W'(quot[i]);
    end
    sum_5_d = term_5[0] + term_5[1] + term_5[2] + term_5[3];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_5_q  <= sum_5_d;
      sing_5_q <= tsing_q[QW-1];
    end
  end

  // ---------------- Stage 6: magnitude of the sum ----------------
  logic [ask_pkg::SM_W-1:0] sm_6_q;
  logic                     sneg_6_q, sing_6_q, vld_6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sm_6_q   <= sum_5_q[ask_pkg::SUM_W-1] ? ask_pkg::SM_W'(-sum_5_q)
                                            : ask_pkg::SM_W'(sum_5_q);
      sneg_6_q <= sum_5_q[ask_pkg::SUM_W-1];
      sing_6_q <= sing_5_q;
    end
  end

  // ---------------- Stage 7: times rigidity ----------------
  logic [ask_pkg::P1_W-1:0] p1_7_q;
  logic                     sneg_7_q, sing_7_q, vld_7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_7_q   <= ask_pkg::P1_W'(sm_6_q) * ask_pkg::P1_W'(rigidity_q);
      sneg_7_q <= sneg_6_q;
      sing_7_q <= sing_6_q;
    end
  end

  // ---------------- Stage 8: times 1/(2*pi), two partial products -------
  logic [ask_pkg::PLO_W+ask_pkg::K_W-1:0] plo_8_q;
  logic [ask_pkg::PHI_W+ask_pkg::K_W-1:0] phi_8_q;
  logic                                   sneg_8_q, sing_8_q, vld_8_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      plo_8_q  <= (ask_pkg::PLO_W+ask_pkg::K_W)'(p1_7_q[ask_pkg::PLO_W-1:0]) *
                  (ask_pkg::PLO_W+ask_pkg::K_W)'(ask_pkg::INV_TWO_PI_Q32);
      phi_8_q  <= (ask_pkg::PHI_W+ask_pkg::K_W)'(p1_7_q[ask_pkg::P1_W-1:ask_pkg::PLO_W]) *
                  (ask_pkg::PHI_W+ask_pkg::K_W)'(ask_pkg::INV_TWO_PI_Q32);
      sneg_8_q <= sneg_7_q;
      sing_8_q <= sing_7_q;
    end
  end

  // ---------------- Stage 9: combine, round half away, shift -------------
  logic [ask_pkg::P_W-1:0] p_9;
  logic [ask_pkg::R_W-1:0] r_9_q;
  logic                    sneg_9_q, sing_9_q, vld_9_q;

  assign p_9 = ask_pkg::P_W'({phi_8_q, {ask_pkg::PLO_W{1'b0}}}) + ask_pkg::P_W'(plo_8_q)
             + (ask_pkg::P_W'(1) << (ask_pkg::SHR - 1));

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_9_q    <= p_9[ask_pkg::P_W-1:ask_pkg::SHR];
      sneg_9_q <= sneg_8_q;
      sing_9_q <= sing_8_q;
    end
  end

  // ---------------- Output stage: saturate, sign, singular -------------
  logic [ask_pkg::RX_W-1:0]  rx;
  logic [ask_pkg::RX_W-1:0]  mag;
  ask_pkg::out_t             out_d, out_q;

  always_comb begin
    rx    = ask_pkg::RX_W'(r_9_q);
    mag   = rx;
    out_d.status = ask_pkg::STATUS_OK;
    if (sneg_9_q) begin
      if (rx > ask_pkg::MAG_MAX_NEG) begin
        mag          = ask_pkg::MAG_MAX_NEG;
        out_d.status = ask_pkg::STATUS_SAT;
      end
      out_d.stress_value = -ask_pkg::OUT_W'(mag);
    end else begin
      if (rx > ask_pkg::MAG_MAX_POS) begin
        mag          = ask_pkg::MAG_MAX_POS;
        out_d.status = ask_pkg::STATUS_SAT;
      end
      out_d.stress_value = ask_pkg::OUT_W'(mag);
    end
    if (sing_9_q) begin
      out_d.stress_value = ask_pkg::SINGULAR_VALUE;
      out_d.status       = ask_pkg::STATUS_SINGULAR;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  // Valid bits for the front-end and back-end stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_1_q     <= 1'b0;
      vld_2_q     <= 1'b0;
      vld_3_q     <= 1'b0;
      vld_4_q     <= 1'b0;
      vld_5_q     <= 1'b0;
      vld_6_q     <= 1'b0;
      vld_7_q     <= 1'b0;
      vld_8_q     <= 1'b0;
      vld_9_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_1_q     <= in_valid_i;
      vld_2_q     <= vld_1_q;
      vld_3_q     <= vld_2_q;
      vld_4_q     <= vld_3_q;
      vld_5_q     <= tvld_q[QW-1];
      vld_6_q     <= vld_5_q;
      vld_7_q     <= vld_6_q;
      vld_8_q     <= vld_7_q;
      vld_9_q     <= vld_8_q;
      out_valid_q <= vld_9_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
